[design/parallel_byte_handshake_sender_assert.svh]
// Assertion macros used by the bound checker, pbhs_checker.
`ifndef PARALLEL_BYTE_HANDSHAKE_SENDER_ASSERT_SVH
`define PARALLEL_BYTE_HANDSHAKE_SENDER_ASSERT_SVH

// Implication checked while out of reset.
`define PBHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset.
`define PBHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication with no reset qualifier, for checks on reset itself.
`define PBHS_ASSERT_RAW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pbhs_pkg.sv]
package pbhs_pkg;

    localparam int LIMIT_W = 16;
    localparam int COUNT_W = LIMIT_W + 1;
    localparam int BYTE_W  = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_HIGH = 2'd1,
        PH_WAIT_LOW  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_BUSY    = 2'd1,
        ST_SENT    = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] data_byte;
        logic              ack_level;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_lines;
        logic              select_control;
        t_status           status;
    } t_result;

endpackage

[design/pbhs_item_if.sv]
interface pbhs_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       ack_level;

    modport source (output valid, mode, data_byte, ack_level, input ready);
    modport sink   (input valid, mode, data_byte, ack_level, output ready);
endinterface

[design/pbhs_result_if.sv]
interface pbhs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_lines;
    logic       select_control;
    logic [1:0] status;

    modport source (output valid, data_lines, select_control, status, input ready);
    modport sink   (input valid, data_lines, select_control, status, output ready);
endinterface

[design/parallel_byte_handshake_sender.sv]
// Channel   | Dir | Payload                                  | Taken when
// ----------+-----+------------------------------------------+-------------------------
// i_in      | in  | mode, data_byte, ack_level               | valid & ready
// o_out     | out | data_lines, select_control, status       | valid & ready
// i_cfg_*   | in  | timeout_limit (16 bit)                   | i_cfg_wr_en high
//
// One word per cycle while the skid is free; its result is registered into o_out.
// A two-entry output buffer (result register plus skid) keeps i_in.ready off
// the o_out.ready path, so input is taken while one result waits downstream.
// Synchronous active-low reset: idle, select released, data lines zero,
// limit 10000. Output stalls back up only once both buffer entries are full.
module parallel_byte_handshake_sender (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pbhs_item_if.sink                    i_in,
    pbhs_result_if.source                o_out,
    input  logic                         i_cfg_wr_en,
    input  logic [pbhs_pkg::LIMIT_W-1:0] i_cfg_wr_data
);
    import pbhs_pkg::*;

    t_item   item;
    t_result ctrl_result;
    t_result out_result;
    logic    in_ready;
    logic    accept;

    // an input word is consumed only when the buffer has room for its result
    assign item   = '{mode: i_in.mode, data_byte: i_in.data_byte, ack_level: i_in.ack_level};
    assign accept = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // handshake phases, poll counter and the held line values
    pbhs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (ctrl_result)
    );

    // result register and skid stage
    pbhs_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (ctrl_result),
        .o_ready     (in_ready),
        .o_valid     (o_out.valid),
        .i_pop_ready (o_out.ready),
        .o_result    (out_result)
    );

    assign o_out.data_lines     = out_result.data_lines;
    assign o_out.select_control = out_result.select_control;
    assign o_out.status         = out_result.status;

endmodule

[design/pbhs_ctrl.sv]
module pbhs_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  pbhs_pkg::t_item              i_item,
    input  logic                         i_cfg_wr_en,
    input  logic [pbhs_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    output pbhs_pkg::t_result            o_result
);
    import pbhs_pkg::*;

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0]  r_data, n_data;
    logic               r_select, n_select;
    logic [LIMIT_W-1:0] r_limit;
    t_status            n_status;

    logic [COUNT_W-1:0] count_inc;
    logic               expired;
    logic               poll;

    assign count_inc = r_count + {{(COUNT_W-1){1'b0}}, 1'b1};
    assign expired   = count_inc > {1'b0, r_limit};
    assign poll      = (i_item.mode == MODE_POLL);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                PH_WAIT_HIGH: begin
                    if (poll) begin
                        if (i_item.ack_level) begin
                            n_phase = PH_WAIT_LOW;
                        end else if (expired) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_WAIT_LOW: begin
                    if (poll && (!i_item.ack_level || expired)) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = poll ? PH_IDLE : PH_WAIT_HIGH;
                end
            endcase
        end
    end

    // datapath and status for the word in hand
    always_comb begin
        n_count  = r_count;
        n_data   = r_data;
        n_select = r_select;
        n_status = ST_IDLE;
        case (r_phase)
            PH_WAIT_HIGH: begin
                n_status = ST_BUSY;
                if (poll) begin
                    n_count = count_inc;
                    if (i_item.ack_level) begin
                        n_select = 1'b1;
                        n_count  = '0;
                    end else if (expired) begin
                        n_select = 1'b1;
                        n_count  = '0;
                        n_status = ST_TIMEOUT;
                    end
                end
            end
            PH_WAIT_LOW: begin
                n_status = ST_BUSY;
                if (poll) begin
                    n_count = count_inc;
                    if (!i_item.ack_level) begin
                        n_count  = '0;
                        n_status = ST_SENT;
                    end else if (expired) begin
                        n_select = 1'b1;
                        n_count  = '0;
                        n_status = ST_TIMEOUT;
                    end
                end
            end
            default: begin
                if (!poll) begin
                    n_data   = i_item.data_byte;
                    n_select = 1'b0;
                    n_count  = '0;
                    n_status = ST_BUSY;
                end
            end
        endcase
    end

    assign o_result = '{data_lines: n_data, select_control: n_select, status: n_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= '0;
            r_data   <= '0;
            r_select <= 1'b1;
            r_limit  <= LIMIT_RESET;
        end else begin
            if (i_accept) begin
                r_phase  <= n_phase;
                r_count  <= n_count;
                r_data   <= n_data;
                r_select <= n_select;
            end
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

endmodule

[design/pbhs_obuf.sv]
module pbhs_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pbhs_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop_ready,
    output pbhs_pkg::t_result o_result
);
    import pbhs_pkg::*;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    drain;

    assign drain    = !r_out_v || i_pop_ready;
    assign o_ready  = !r_skid_v;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (drain) begin
            // skid full means no push this cycle
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out <= r_skid_v ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

[design/pbhs_checker.sv]
module pbhs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_lines,
    input logic       i_select_control,
    input logic [1:0] i_status
);
    import pbhs_pkg::*;

    `include "parallel_byte_handshake_sender_assert.svh"

    // reset empties the result buffer
    `PBHS_ASSERT_RAW(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    // a stalled result holds
    `PBHS_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_data_lines, i_select_control, i_status}), "stalled result changed")

    // select is released whenever no transfer is running
    `PBHS_ASSERT_IMP(a_select_rel, i_clk, i_rst_n, i_out_valid && (i_status != ST_BUSY), i_select_control, "select low outside a transfer")

    // with nothing waiting on the output, input must be open
    `PBHS_ASSERT_IMP(a_ready_open, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input blocked with empty output")

    // a word taken in shows a result word on the next cycle
    `PBHS_ASSERT_NXT(a_take_shows, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "taken word left no result")

endmodule

bind parallel_byte_handshake_sender pbhs_checker u_pbhs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_data_lines     (o_out.data_lines),
    .i_select_control (o_out.select_control),
    .i_status         (o_out.status)
);

[tb/pbhs_sender_checker.sv]
`timescale 1ns / 100ps

// Watches both channels and the limit port. Keeps its own copy of the sender
// state and compares every result word with the oldest predicted one.
module pbhs_sender_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pbhs_item_if                         item_bus,
    pbhs_result_if                       result_bus,
    input  logic                         i_cfg_wr_en,
    input  logic [pbhs_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    output int                           o_mismatches,
    output int                           o_outstanding,
    output int                           o_checked,
    output int                           o_sent,
    output int                           o_timeouts
);
    import pbhs_pkg::*;

    t_phase             ln_phase;
    logic [COUNT_W-1:0] ln_count;
    logic [BYTE_W-1:0]  ln_data;
    logic               ln_select;
    logic [LIMIT_W-1:0] ln_limit;

    t_result            line_queue[$];
    int                 mismatch_cnt;
    int                 checked_cnt;
    int                 sent_cnt;
    int                 timeout_cnt;

    // One word through the handshake state; returns the line state it shows.
    function automatic t_result advance_sender(input t_item w);
        t_result r;
        logic    busy;
        logic    met;
        busy     = (ln_phase == PH_WAIT_HIGH) || (ln_phase == PH_WAIT_LOW);
        r.status = ST_IDLE;
        if (w.mode == MODE_SEND) begin
            if (!busy) begin
                ln_data   = w.data_byte;
                ln_select = 1'b0;
                ln_phase  = PH_WAIT_HIGH;
                ln_count  = '0;
            end
            r.status = ST_BUSY;
        end else if (busy) begin
            met      = (ln_phase == PH_WAIT_HIGH) ? w.ack_level : !w.ack_level;
            ln_count = ln_count + 1'b1;
            if (met) begin
                ln_count = '0;
                if (ln_phase == PH_WAIT_HIGH) begin
                    ln_select = 1'b1;
                    ln_phase  = PH_WAIT_LOW;
                    r.status  = ST_BUSY;
                end else begin
                    ln_phase = PH_IDLE;
                    r.status = ST_SENT;
                end
            end else if (ln_count > {1'b0, ln_limit}) begin
                ln_select = 1'b1;
                ln_phase  = PH_IDLE;
                ln_count  = '0;
                r.status  = ST_TIMEOUT;
            end else begin
                r.status = ST_BUSY;
            end
        end else begin
            ln_phase = PH_IDLE;
        end
        r.data_lines     = ln_data;
        r.select_control = ln_select;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        t_item   w;
        if (!i_rst_n) begin
            ln_phase  = PH_IDLE;
            ln_count  = '0;
            ln_data   = '0;
            ln_select = 1'b1;
            ln_limit  = LIMIT_RESET;
            line_queue.delete();
        end else begin
            if (i_cfg_wr_en)
                ln_limit = i_cfg_wr_data;
            // results first: a word taken this edge cannot show yet
            if (result_bus.valid && result_bus.ready) begin
                if (line_queue.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatch_cnt++;
                end else begin
                    exp_r = line_queue.pop_front();
                    check_field("data_lines", exp_r.data_lines, result_bus.data_lines);
                    check_field("select_control", exp_r.select_control,
                                result_bus.select_control);
                    check_field("status", exp_r.status, result_bus.status);
                    checked_cnt++;
                    if (exp_r.status == ST_SENT)
                        sent_cnt++;
                    if (exp_r.status == ST_TIMEOUT)
                        timeout_cnt++;
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                w.mode      = item_bus.mode;
                w.data_byte = item_bus.data_byte;
                w.ack_level = item_bus.ack_level;
                line_queue.push_back(advance_sender(w));
            end
        end
        o_outstanding <= line_queue.size();
        o_mismatches  <= mismatch_cnt;
        o_checked     <= checked_cnt;
        o_sent        <= sent_cnt;
        o_timeouts    <= timeout_cnt;
    end

endmodule

[tb/tb_parallel_byte_handshake_sender.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the parallel byte sender. Prediction and
// comparison live in the checker beside the DUT.
module tb_parallel_byte_handshake_sender;
    import pbhs_pkg::*;

    localparam int RANDOM_WORDS   = 400;
    localparam int SETTLE_CYCLES  = 4;    // result is registered, plus skid
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 1000; // cycles with no word moving

    // how the receiving side paces its ready
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_RANDOM,
        PACE_PERIODIC,
        PACE_BURSTY
    } t_sink_pace;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic               sink_ready = 1'b1;

    int                 mismatches;
    int                 outstanding;
    int                 checked;
    int                 sent_bytes;
    int                 timeouts;

    int                 words_sent;
    int                 settings_cnt;
    int                 burst_left;
    bit                 gaps_on;
    int                 idle_cycles;

    pbhs_item_if   in_bus ();
    pbhs_result_if out_bus ();

    assign out_bus.ready = sink_ready;

    parallel_byte_handshake_sender DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_bus),
        .o_out        (out_bus),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    pbhs_sender_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .item_bus     (in_bus),
        .result_bus   (out_bus),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding),
        .o_checked    (checked),
        .o_sent       (sent_bytes),
        .o_timeouts   (timeouts)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: picks a pacing style for a random span of cycles. Bursty mode
    // at times holds ready low for a random hold, enough to fill the skid.
    always @(posedge clk) begin
        t_sink_pace pace;
        int         span_left;
        int         hold_left;
        int         tick;
        tick++;
        if (!rst_n) begin
            sink_ready <= 1'b1;
            span_left = 0;
            hold_left = 0;
        end else begin
            if (span_left == 0) begin
                pace      = t_sink_pace'($urandom_range(0, 3));
                span_left = $urandom_range(20, 80);
            end
            span_left--;
            case (pace)
                PACE_FREE: begin
                    sink_ready <= 1'b1;
                end
                PACE_RANDOM: begin
                    sink_ready <= ($urandom_range(0, 3) != 0);
                end
                PACE_PERIODIC: begin
                    sink_ready <= ((tick % 5) != 0);
                end
                default: begin
                    if (hold_left > 0) begin
                        hold_left--;
                        sink_ready <= 1'b0;
                    end else begin
                        sink_ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            hold_left = $urandom_range(1, 15);
                    end
                end
            endcase
        end
    end

    // Watchdog: a run that stops moving words is a hang, not a slow pass.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("parallel_byte_handshake_sender test failed");
                $finish;
            end
        end
    end

    // Present one word and hold it until taken. Bursts of random length are
    // broken by short gaps when gaps are switched on for the phase.
    task automatic drive_word(input logic m, input logic [BYTE_W-1:0] b, input logic a);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                in_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_bus.valid     <= 1'b1;
        in_bus.mode      <= m;
        in_bus.data_byte <= b;
        in_bus.ack_level <= a;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        drive_word(MODE_SEND, b, 1'($urandom_range(0, 1)));
    endtask

    task automatic poll(input logic a);
        drive_word(MODE_POLL, 8'($urandom), a);
    endtask

    // Stop offering words and wait until every result has drained, then wait
    // out SETTLE_CYCLES as well so the output stage is empty.
    task automatic settle_idle();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_cnt++;
    endtask

    initial begin
        int lim;
        int cap;
        int k;
        int ph;
        int pick;
        int phase_end;
        int random_start;
        bit abandon;

        in_bus.valid     <= 1'b0;
        in_bus.mode      <= MODE_POLL;
        in_bus.data_byte <= '0;
        in_bus.ack_level <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        rst_n            <= 1'b0;
        gaps_on = 1'b0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset limit of 10000 ---
        // polls while idle change nothing
        poll(1'b0);
        poll(1'b1);
        // full handshake on 0x00, with a send while busy that must be ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        poll(1'b0);
        poll(1'b1);
        poll(1'b1);
        poll(1'b0);
        // status drops back to idle after completion, lines keep the byte
        poll(1'b1);
        send_byte(8'hFF);
        poll(1'b1);
        poll(1'b0);

        // limit of zero: first unmet poll of either phase times out
        write_limit('0);
        send_byte(8'hA5);
        poll(1'b0);
        send_byte(8'h5A);
        poll(1'b1);
        poll(1'b1);

        // limit of two: met on the last allowed poll passes, one more fails
        write_limit(LIMIT_W'(2));
        send_byte(8'h3C);
        poll(1'b0);
        poll(1'b0);
        poll(1'b1);
        poll(1'b1);
        poll(1'b1);
        poll(1'b1);

        // limit lowered in the middle of a phase keeps the running count
        write_limit('1);
        send_byte(8'hC3);
        poll(1'b0);
        write_limit(LIMIT_W'(1));
        poll(1'b0);

        // --- random part: phases of one limit setting each ---
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                lim = $urandom_range(0, 4);
            else if (pick < 8)
                lim = $urandom_range(5, 12);
            else if (pick == 8)
                lim = 65535;
            else
                lim = $urandom_range(0, 65535);
            write_limit(LIMIT_W'(lim));
            cap       = (lim > 6) ? 6 : lim;
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_end = words_sent + $urandom_range(30, 60);
            while (words_sent < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    // noise
                    drive_word(1'($urandom_range(0, 1)), 8'($urandom),
                               1'($urandom_range(0, 1)));
                end else if (pick == 1) begin
                    poll(1'($urandom_range(0, 1)));
                end else begin
                    // well-formed transfer; unmet polls may run past the limit,
                    // and now and then the transfer is left hanging
                    send_byte(8'($urandom));
                    abandon = 1'b0;
                    for (ph = 0; ph < 2 && !abandon; ph++) begin
                        k = $urandom_range(0, cap + 2);
                        repeat (k) begin
                            if ($urandom_range(0, 7) == 0)
                                send_byte(8'($urandom));
                            else
                                poll((ph == 0) ? 1'b0 : 1'b1);
                        end
                        poll((ph == 0) ? 1'b1 : 1'b0);
                        abandon = ($urandom_range(0, 11) == 0);
                    end
                end
            end
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d words and %0d checked results over %0d limit settings.",
                 words_sent, checked, settings_cnt);
        $display("Transfers completed: %0d, timed out: %0d.", sent_bytes, timeouts);
        if (mismatches == 0 && outstanding == 0) begin
            $display("parallel_byte_handshake_sender test passed");
        end else begin
            $display("parallel_byte_handshake_sender test failed");
        end
        $finish;
    end

endmodule
